### design/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and codes of the 24-bit BMP stream decoder: result kinds,
// status codes, decoder phases and the structs passed between its modules.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  // result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SMALL       = 4'd1;
  localparam logic [3:0] ST_SIGNATURE   = 4'd2;
  localparam logic [3:0] ST_INFO_SIZE   = 4'd3;
  localparam logic [3:0] ST_PLANES      = 4'd4;
  localparam logic [3:0] ST_DEPTH       = 4'd5;
  localparam logic [3:0] ST_COMPRESSION = 4'd6;
  localparam logic [3:0] ST_DIMS        = 4'd7;
  localparam logic [3:0] ST_OFFSET      = 4'd8;
  localparam logic [3:0] ST_TRUNCATED   = 4'd9;
  localparam logic [3:0] ST_TOO_LARGE   = 4'd10;

  // decoder phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PIXELS = 2'd1;
  localparam logic [1:0] PH_IGNORE = 2'd2;

  // per-byte control from the top level
  typedef struct packed {
    logic        step;   // byte request accepted this cycle
    logic        clear;  // last byte of the file, stream state returns to reset
    logic [1:0]  phase;
    logic [31:0] pos;
  } ctl_t;

  // header view handed to the pixel path and the result mux
  typedef struct packed {
    logic [3:0]  err;       // error status raised by this byte, header phase only
    logic        ok;        // header accepted on this byte
    logic [31:0] offset;
    logic [33:0] stride;
    logic [33:0] width3;
    logic [31:0] raw_width;
    logic [31:0] abs_h;
    logic        from_top;
    logic [14:0] img_w;
    logic [14:0] img_h;
  } hdr_t;

  typedef struct packed {
    logic        emit;
    logic        last;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [13:0] column;
    logic [13:0] row;
  } pix_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [13:0] column;
    logic [13:0] row;
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic        last_pixel;
  } result_t;

endpackage

### design/bmpd_if.sv
// ----------------------------------------------------------------------------
// bmpd channel interfaces
// Valid/ready channels of the decoder: file bytes in, results out and the
// file length register write.
// ----------------------------------------------------------------------------
interface bmpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface bmpd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  status;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [13:0] column;
  logic [13:0] row;
  logic [14:0] image_width;
  logic [14:0] image_height;
  logic        last_pixel;

  modport source (output valid, output kind, output status, output red, output green,
                  output blue, output column, output row, output image_width,
                  output image_height, output last_pixel, input ready);
  modport sink (input valid, input kind, input status, input red, input green,
                input blue, input column, input row, input image_width,
                input image_height, input last_pixel, output ready);
endinterface

interface bmpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] file_length;

  modport source (output valid, output file_length, input ready);
  modport sink (input valid, input file_length, output ready);
endinterface

### design/bmpd_hdr.sv
// ----------------------------------------------------------------------------
// bmpd_hdr
// Header capture and checks: gathers the little-endian header fields, works
// out the row stride and the pixel array size on the way, and gives the
// status of the header on its last byte.
// ----------------------------------------------------------------------------
module bmpd_hdr #(
  parameter int unsigned MAX_WIDTH  = 16384,
  parameter int unsigned MAX_HEIGHT = 16384
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bmpd_pkg::ctl_t   ctl_i,
  input  logic [7:0]       data_byte_i,
  input  logic [31:0]      file_length_i,
  output bmpd_pkg::hdr_t   hdr_o
);

  localparam logic [31:0] POS_SIG0     = 32'd0;
  localparam logic [31:0] POS_SIG1     = 32'd1;
  localparam logic [31:0] POS_OFFSET   = 32'd10;
  localparam logic [31:0] POS_INFO     = 32'd14;
  localparam logic [31:0] POS_WIDTH    = 32'd18;
  localparam logic [31:0] POS_HEIGHT   = 32'd22;
  localparam logic [31:0] POS_PLANES   = 32'd26;
  localparam logic [31:0] POS_DEPTH    = 32'd28;
  localparam logic [31:0] POS_COMP     = 32'd30;
  localparam logic [31:0] POS_MAC_LAST = 32'd30;
  localparam logic [31:0] POS_LAST     = 32'd33;

  localparam logic [7:0]  SIG_B        = 8'h42;
  localparam logic [7:0]  SIG_M        = 8'h4d;
  localparam logic [31:0] MIN_FILE_LEN = 32'd54;
  localparam logic [31:0] MIN_INFO     = 32'd40;
  localparam logic [32:0] FILE_HDR_LEN = 33'd14;
  localparam logic [15:0] REQ_PLANES   = 16'd1;
  localparam logic [15:0] REQ_DEPTH    = 16'd24;
  localparam logic [31:0] LIM_W        = 32'(MAX_WIDTH);
  localparam logic [31:0] LIM_H        = 32'(MAX_HEIGHT);

  logic [7:0]  sig_q, sig_d;
  logic [31:0] offset_q, offset_d;
  logic [31:0] info_q, info_d;
  logic [31:0] rw_q, rw_d;
  logic [31:0] rh_q, rh_d;
  logic [15:0] plane_q, plane_d;
  logic [15:0] depth_q, depth_d;
  logic [23:0] comp_q, comp_d;
  logic [33:0] stride_q, stride_d;
  logic [33:0] width3_q, width3_d;
  logic [31:0] absh_q, absh_d;
  logic [31:0] macc_q, macc_d;
  logic        msat_q, msat_d;

  logic        hdr_step;
  logic [1:0]  off_lane, info_lane, rw_lane, rh_lane, mac_lane;
  logic        plane_lane, depth_lane;
  logic [33:0] w3_calc;
  logic [7:0]  h_byte;
  logic [41:0] prod;
  logic [42:0] mac_sum;
  logic [32:0] fl33;
  logic        trunc;
  logic [3:0]  status;
  logic [3:0]  err;

  assign hdr_step   = ctl_i.step && (ctl_i.phase == bmpd_pkg::PH_HEADER);
  assign off_lane   = 2'(ctl_i.pos - POS_OFFSET);
  assign info_lane  = 2'(ctl_i.pos - POS_INFO);
  assign rw_lane    = 2'(ctl_i.pos - POS_WIDTH);
  assign rh_lane    = 2'(ctl_i.pos - POS_HEIGHT);
  assign plane_lane = ctl_i.pos[0] ^ POS_PLANES[0];
  assign depth_lane = ctl_i.pos[0] ^ POS_DEPTH[0];
  // multiply steps take the height bytes most significant first
  assign mac_lane   = 2'(POS_MAC_LAST - ctl_i.pos);

  assign w3_calc = {2'b00, rw_q} + {1'b0, rw_q, 1'b0};
  assign h_byte  = absh_q[8*mac_lane +: 8];
  assign prod    = 42'(stride_q) * 42'(h_byte);
  assign mac_sum = {3'b000, macc_q, 8'h00} + {1'b0, prod};

  assign fl33  = {1'b0, file_length_i};
  assign trunc = msat_q || (({1'b0, offset_q} + {1'b0, macc_q}) > fl33);

  // header checks in priority order
  always_comb begin
    if (info_q < MIN_INFO || ({1'b0, info_q} + FILE_HDR_LEN) > fl33) begin
      status = bmpd_pkg::ST_INFO_SIZE;
    end else if (plane_q != REQ_PLANES) begin
      status = bmpd_pkg::ST_PLANES;
    end else if (depth_q != REQ_DEPTH) begin
      status = bmpd_pkg::ST_DEPTH;
    end else if (comp_q != 24'd0 || data_byte_i != 8'd0) begin
      status = bmpd_pkg::ST_COMPRESSION;
    end else if (rw_q == 32'd0 || rw_q[31] || rh_q == 32'd0) begin
      status = bmpd_pkg::ST_DIMS;
    end else if (offset_q < MIN_FILE_LEN || offset_q >= file_length_i) begin
      status = bmpd_pkg::ST_OFFSET;
    end else if (trunc) begin
      status = bmpd_pkg::ST_TRUNCATED;
    end else if (rw_q > LIM_W || absh_q > LIM_H) begin
      status = bmpd_pkg::ST_TOO_LARGE;
    end else begin
      status = bmpd_pkg::ST_OK;
    end
  end

  always_comb begin
    err = bmpd_pkg::ST_OK;
    if (ctl_i.pos == POS_SIG0) begin
      if (file_length_i < MIN_FILE_LEN) begin
        err = bmpd_pkg::ST_SMALL;
      end
    end else if (ctl_i.pos == POS_SIG1) begin
      if (sig_q != SIG_B || data_byte_i != SIG_M) begin
        err = bmpd_pkg::ST_SIGNATURE;
      end
    end else if (ctl_i.pos == POS_LAST) begin
      err = status;
    end
  end

  always_comb begin
    sig_d    = sig_q;
    offset_d = offset_q;
    info_d   = info_q;
    rw_d     = rw_q;
    rh_d     = rh_q;
    plane_d  = plane_q;
    depth_d  = depth_q;
    comp_d   = comp_q;
    stride_d = stride_q;
    width3_d = width3_q;
    absh_d   = absh_q;
    macc_d   = macc_q;
    msat_d   = msat_q;
    if (hdr_step) begin
      if (ctl_i.pos == POS_SIG0) begin
        sig_d = data_byte_i;
      end
      if (ctl_i.pos >= POS_OFFSET && ctl_i.pos < POS_INFO) begin
        offset_d[8*off_lane +: 8] = data_byte_i;
      end
      if (ctl_i.pos >= POS_INFO && ctl_i.pos < POS_WIDTH) begin
        info_d[8*info_lane +: 8] = data_byte_i;
      end
      if (ctl_i.pos >= POS_WIDTH && ctl_i.pos < POS_HEIGHT) begin
        rw_d[8*rw_lane +: 8] = data_byte_i;
      end
      if (ctl_i.pos >= POS_HEIGHT && ctl_i.pos < POS_PLANES) begin
        rh_d[8*rh_lane +: 8] = data_byte_i;
      end
      if (ctl_i.pos >= POS_PLANES && ctl_i.pos < POS_DEPTH) begin
        plane_d[8*plane_lane +: 8] = data_byte_i;
      end
      if (ctl_i.pos >= POS_DEPTH && ctl_i.pos < POS_COMP) begin
        depth_d[8*depth_lane +: 8] = data_byte_i;
      end
      if (ctl_i.pos >= POS_COMP && ctl_i.pos < POS_LAST) begin
        comp_d[8*(2'(ctl_i.pos - POS_COMP)) +: 8] = data_byte_i;
      end
      // width is complete once the first height byte arrives
      if (ctl_i.pos == POS_HEIGHT) begin
        width3_d = w3_calc;
        stride_d = (w3_calc + 34'd3) & ~34'd3;
      end
      if (ctl_i.pos == POS_PLANES) begin
        absh_d = rh_q[31] ? (~rh_q + 32'd1) : rh_q;
      end
      // stride times height, one height byte per request, 32-bit overflow flagged
      if (ctl_i.pos > POS_PLANES && ctl_i.pos <= POS_MAC_LAST) begin
        macc_d = mac_sum[31:0];
        msat_d = msat_q | (|mac_sum[42:32]);
      end
    end
    if (ctl_i.clear) begin
      sig_d    = '0;
      offset_d = '0;
      info_d   = '0;
      rw_d     = '0;
      rh_d     = '0;
      plane_d  = '0;
      depth_d  = '0;
      comp_d   = '0;
      stride_d = '0;
      width3_d = '0;
      absh_d   = '0;
      macc_d   = '0;
      msat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q    <= '0;
      offset_q <= '0;
      info_q   <= '0;
      rw_q     <= '0;
      rh_q     <= '0;
      plane_q  <= '0;
      depth_q  <= '0;
      comp_q   <= '0;
      stride_q <= '0;
      width3_q <= '0;
      absh_q   <= '0;
      macc_q   <= '0;
      msat_q   <= 1'b0;
    end else begin
      sig_q    <= sig_d;
      offset_q <= offset_d;
      info_q   <= info_d;
      rw_q     <= rw_d;
      rh_q     <= rh_d;
      plane_q  <= plane_d;
      depth_q  <= depth_d;
      comp_q   <= comp_d;
      stride_q <= stride_d;
      width3_q <= width3_d;
      absh_q   <= absh_d;
      macc_q   <= macc_d;
      msat_q   <= msat_d;
    end
  end

  always_comb begin
    hdr_o.err       = err;
    hdr_o.ok        = (ctl_i.pos == POS_LAST) && (status == bmpd_pkg::ST_OK);
    hdr_o.offset    = offset_q;
    hdr_o.stride    = stride_q;
    hdr_o.width3    = width3_q;
    hdr_o.raw_width = rw_q;
    hdr_o.abs_h     = absh_q;
    hdr_o.from_top  = rh_q[31];
    hdr_o.img_w     = rw_q[14:0];
    hdr_o.img_h     = absh_q[14:0];
  end

endmodule

### design/bmpd_pix.sv
// ----------------------------------------------------------------------------
// bmpd_pix
// Pixel path: walks each padded row, gathers blue and green, and on the red
// byte gives one pixel with its column and its destination row.
// ----------------------------------------------------------------------------
module bmpd_pix #(
  parameter int unsigned MAX_WIDTH  = 16384,
  parameter int unsigned MAX_HEIGHT = 16384
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bmpd_pkg::ctl_t   ctl_i,
  input  logic [7:0]       data_byte_i,
  input  bmpd_pkg::hdr_t   hdr_i,
  output bmpd_pkg::pix_t   pix_o
);

  localparam int RBW = $clog2(3 * MAX_WIDTH + 4);
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [RBW-1:0] rbp_q, rbp_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  srow_q, srow_d;
  logic [1:0]     chan_q, chan_d;
  logic [7:0]     blue_q, blue_d;
  logic [7:0]     green_q, green_d;
  logic [CW-1:0]  wm1_q, wm1_d;
  logic [RW-1:0]  hm1_q, hm1_d;
  logic           top_q, top_d;

  logic           active;
  logic           start;
  logic           in_row;
  logic [RBW-1:0] rbp_inc;
  logic           row_end;
  logic           emit;
  logic           last;
  logic [RW-1:0]  drow;

  assign active  = ctl_i.step && (ctl_i.phase == bmpd_pkg::PH_PIXELS) &&
                   (ctl_i.pos >= hdr_i.offset);
  assign start   = ctl_i.step && (ctl_i.phase == bmpd_pkg::PH_HEADER) && hdr_i.ok;
  assign in_row  = 34'(rbp_q) < hdr_i.width3;
  assign rbp_inc = rbp_q + 1'b1;
  assign row_end = 34'(rbp_inc) >= hdr_i.stride;
  assign emit    = active && in_row && (chan_q == 2'd2);
  assign last    = (srow_q == hm1_q) && (col_q == wm1_q);
  assign drow    = top_q ? srow_q : (hm1_q - srow_q);

  always_comb begin
    rbp_d   = rbp_q;
    col_d   = col_q;
    srow_d  = srow_q;
    chan_d  = chan_q;
    blue_d  = blue_q;
    green_d = green_q;
    wm1_d   = wm1_q;
    hm1_d   = hm1_q;
    top_d   = top_q;
    if (start) begin
      wm1_d = CW'(hdr_i.raw_width - 32'd1);
      hm1_d = RW'(hdr_i.abs_h - 32'd1);
      top_d = hdr_i.from_top;
    end
    if (active) begin
      if (in_row) begin
        case (chan_q)
          2'd0: begin
            blue_d = data_byte_i;
            chan_d = 2'd1;
          end
          2'd1: begin
            green_d = data_byte_i;
            chan_d  = 2'd2;
          end
          default: begin
            chan_d = 2'd0;
            col_d  = col_q + 1'b1;
          end
        endcase
      end
      rbp_d = rbp_inc;
      // padding done, next source row
      if (row_end) begin
        rbp_d  = '0;
        col_d  = '0;
        chan_d = 2'd0;
        srow_d = srow_q + 1'b1;
      end
    end
    if (ctl_i.clear) begin
      rbp_d   = '0;
      col_d   = '0;
      srow_d  = '0;
      chan_d  = 2'd0;
      blue_d  = '0;
      green_d = '0;
      wm1_d   = '0;
      hm1_d   = '0;
      top_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbp_q   <= '0;
      col_q   <= '0;
      srow_q  <= '0;
      chan_q  <= 2'd0;
      blue_q  <= '0;
      green_q <= '0;
      wm1_q   <= '0;
      hm1_q   <= '0;
      top_q   <= 1'b0;
    end else begin
      rbp_q   <= rbp_d;
      col_q   <= col_d;
      srow_q  <= srow_d;
      chan_q  <= chan_d;
      blue_q  <= blue_d;
      green_q <= green_d;
      wm1_q   <= wm1_d;
      hm1_q   <= hm1_d;
      top_q   <= top_d;
    end
  end

  always_comb begin
    pix_o.emit   = emit;
    pix_o.last   = emit && last;
    pix_o.red    = data_byte_i;
    pix_o.green  = green_q;
    pix_o.blue   = blue_q;
    pix_o.column = 14'(col_q);
    pix_o.row    = 14'(drow);
  end

endmodule

### design/bmpd_outq.sv
// ----------------------------------------------------------------------------
// bmpd_outq
// Two-entry result queue: holds finished results so that byte requests keep
// flowing while the result side stalls.
// ----------------------------------------------------------------------------
module bmpd_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bmpd_pkg::result_t   push_data_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                ready_i,
  output bmpd_pkg::result_t   data_o
);

  bmpd_pkg::result_t slot0_q, slot0_d;
  bmpd_pkg::result_t slot1_q, slot1_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              pop;

  assign pop     = (cnt_q != 2'd0) && ready_i;
  assign valid_o = cnt_q != 2'd0;
  assign space_o = cnt_q != 2'd2;
  assign data_o  = slot0_q;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (pop && push_i) begin
      if (cnt_q == 2'd1) begin
        slot0_d = push_data_i;
      end else begin
        slot0_d = slot1_q;
        slot1_d = push_data_i;
      end
    end else if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        slot0_d = push_data_i;
      end else begin
        slot1_d = push_data_i;
      end
      cnt_d = cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

### design/bmp24_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// bmp24_stream_decoder_core
// Streaming decoder for uncompressed 24-bit BMP files: checks the header,
// then turns each BGR triple into one RGB pixel with its position.
//
//   channel   dir  payload                                   handshake
//   byte_i    in   data_byte                                 valid/ready
//   result_o  out  kind, status, rgb, column, row, size, last  valid/ready
//   cfg_i     in   file_length                               valid/ready (always ready)
//
// One byte request is taken per cycle while the result queue has space; its result,
// if any, is registered in the queue and shown after the results ahead of it.
// A two-entry result queue sets the stall behaviour: bytes keep flowing until
// both entries hold results that the sink has not taken.
// The stride times height product is built one height byte per request
// during header bytes 27 to 30; the byte stream is not held for it.
// Reset is asynchronous, active low; there is no clearing pass.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder_core #(
  parameter int unsigned MAX_WIDTH  = 16384,
  parameter int unsigned MAX_HEIGHT = 16384
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bmpd_cfg_if.sink         cfg_i,
  bmpd_byte_if.sink        byte_i,
  bmpd_result_if.source    result_o
);

  localparam logic [31:0] FILE_LEN_RST = 32'd54;

  logic [31:0] file_len_q;
  logic [31:0] pos_q, pos_d;
  logic [1:0]  phase_q, phase_d;

  logic              step;
  logic              eof;
  logic              space;
  logic              push;
  bmpd_pkg::ctl_t    ctl;
  bmpd_pkg::hdr_t    hdr;
  bmpd_pkg::pix_t    pix;
  bmpd_pkg::result_t res_d;
  bmpd_pkg::result_t res_q;

  assign cfg_i.ready  = 1'b1;
  assign byte_i.ready = space;
  assign step         = byte_i.valid && space;
  assign eof          = ({1'b0, pos_q} + 33'd1) >= {1'b0, file_len_q};

  always_comb begin
    ctl.step  = step;
    ctl.clear = step && eof;
    ctl.phase = phase_q;
    ctl.pos   = pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len_q <= FILE_LEN_RST;
    end else if (cfg_i.valid) begin
      file_len_q <= cfg_i.file_length;
    end
  end

  bmpd_hdr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_hdr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .data_byte_i   (byte_i.data_byte),
    .file_length_i (file_len_q),
    .hdr_o         (hdr)
  );

  bmpd_pix #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .data_byte_i (byte_i.data_byte),
    .hdr_i       (hdr),
    .pix_o       (pix)
  );

  always_comb begin
    push    = 1'b0;
    res_d   = '0;
    phase_d = phase_q;
    pos_d   = pos_q;
    if (step) begin
      unique case (phase_q)
        bmpd_pkg::PH_HEADER: begin
          if (hdr.err != bmpd_pkg::ST_OK) begin
            push         = 1'b1;
            res_d.kind   = bmpd_pkg::KIND_ERROR;
            res_d.status = hdr.err;
            phase_d      = bmpd_pkg::PH_IGNORE;
          end else if (hdr.ok) begin
            push               = 1'b1;
            res_d.kind         = bmpd_pkg::KIND_HEADER;
            res_d.status       = bmpd_pkg::ST_OK;
            res_d.image_width  = hdr.img_w;
            res_d.image_height = hdr.img_h;
            phase_d            = bmpd_pkg::PH_PIXELS;
          end
        end
        bmpd_pkg::PH_PIXELS: begin
          if (pix.emit) begin
            push             = 1'b1;
            res_d.kind       = bmpd_pkg::KIND_PIXEL;
            res_d.status     = bmpd_pkg::ST_OK;
            res_d.red        = pix.red;
            res_d.green      = pix.green;
            res_d.blue       = pix.blue;
            res_d.column     = pix.column;
            res_d.row        = pix.row;
            res_d.last_pixel = pix.last;
            if (pix.last) begin
              phase_d = bmpd_pkg::PH_IGNORE;
            end
          end
        end
        default: ;
      endcase
      // end of file: back to the start of a new file
      if (eof) begin
        phase_d = bmpd_pkg::PH_HEADER;
        pos_d   = '0;
      end else begin
        pos_d = pos_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= bmpd_pkg::PH_HEADER;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
    end
  end

  bmpd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res_d),
    .space_o     (space),
    .valid_o     (result_o.valid),
    .ready_i     (result_o.ready),
    .data_o      (res_q)
  );

  assign result_o.kind         = res_q.kind;
  assign result_o.status       = res_q.status;
  assign result_o.red          = res_q.red;
  assign result_o.green        = res_q.green;
  assign result_o.blue         = res_q.blue;
  assign result_o.column       = res_q.column;
  assign result_o.row          = res_q.row;
  assign result_o.image_width  = res_q.image_width;
  assign result_o.image_height = res_q.image_height;
  assign result_o.last_pixel   = res_q.last_pixel;

endmodule

### design/bmpd_checker.sv
// ----------------------------------------------------------------------------
// bmpd_checker
// Port-level checks of the decoder results: field contents per result kind
// and a stalled result that holds.
// ----------------------------------------------------------------------------
module bmpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic [3:0]  status_i,
  input logic [7:0]  red_i,
  input logic [7:0]  green_i,
  input logic [7:0]  blue_i,
  input logic [13:0] column_i,
  input logic [13:0] row_i,
  input logic [14:0] image_width_i,
  input logic [14:0] image_height_i,
  input logic        last_pixel_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
    $stable(status_i) && $stable(column_i) && $stable(row_i) && $stable(red_i))
    else $error("stalled result changed");

  a_pixel_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == bmpd_pkg::KIND_PIXEL |->
    status_i == bmpd_pkg::ST_OK && image_width_i == 15'd0 && image_height_i == 15'd0)
    else $error("pixel result carries header fields");

  a_header_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == bmpd_pkg::KIND_HEADER |->
    status_i == bmpd_pkg::ST_OK && !last_pixel_i && column_i == 14'd0 &&
    row_i == 14'd0 && red_i == 8'd0 && green_i == 8'd0 && blue_i == 8'd0)
    else $error("header result carries pixel fields");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == bmpd_pkg::KIND_ERROR |->
    status_i != bmpd_pkg::ST_OK && !last_pixel_i && column_i == 14'd0 &&
    row_i == 14'd0 && image_width_i == 15'd0 && image_height_i == 15'd0)
    else $error("error result malformed");

endmodule

bind bmp24_stream_decoder_core bmpd_checker u_bmpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .kind_i         (result_o.kind),
  .status_i       (result_o.status),
  .red_i          (result_o.red),
  .green_i        (result_o.green),
  .blue_i         (result_o.blue),
  .column_i       (result_o.column),
  .row_i          (result_o.row),
  .image_width_i  (result_o.image_width),
  .image_height_i (result_o.image_height),
  .last_pixel_i   (result_o.last_pixel)
);

### sim/tb_bmp24_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_bmp24_stream_decoder_core
// Self-checking bench for the 24-bit BMP stream decoder. Whole BMP files,
// well-formed, damaged or plain noise, are streamed in with random gaps and
// random back-pressure on the result side. A cycle-free model of the decoder
// in the bench predicts each header, error and pixel result, and every
// result the block gives is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_bmp24_stream_decoder_core;

  localparam int unsigned MAX_W = 16384;
  localparam int unsigned MAX_H = 16384;
  localparam bit [7:0]  SIG_B    = 8'h42;
  localparam bit [7:0]  SIG_M    = 8'h4D;
  localparam bit [31:0] INFO_LEN = 32'd40;
  localparam bit [31:0] HDR_LEN  = 32'd54;
  localparam bit [15:0] BPP_24   = 16'd24;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bmpd_cfg_if    cfg_if();
  bmpd_byte_if   byte_if();
  bmpd_result_if res_if();

  bmp24_stream_decoder_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_if),
    .byte_i  (byte_if),
    .result_o(res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // decoder state as the bench sees it
  bit [31:0]   file_len;
  bit [31:0]   at_pos;
  logic [1:0]  stage;
  bit [31:0]   pix_off;
  bit [31:0]   info_len;
  bit [31:0]   w_raw;
  bit [31:0]   h_raw;
  bit [15:0]   planes_val;
  bit [15:0]   bpp_val;
  bit [31:0]   comp_val;
  bit [31:0]   row_bytes;
  bit [31:0]   col_cnt;
  bit [31:0]   src_rows;
  bit [1:0]    chan;
  bit [7:0]    keep_b;
  bit [7:0]    keep_g;

  bmpd_pkg::result_t due_results[$];
  bit [7:0]    file_img[$];
  int unsigned err_count;
  int unsigned src_odds;
  int unsigned sink_odds;
  int unsigned hold_odds;

  function automatic bit [31:0] height_abs(input bit [31:0] h);
    return h[31] ? (~h + 32'd1) : h;
  endfunction

  // row length in bytes, padded to a multiple of four, without wrap-around
  function automatic longint unsigned padded_stride(input bit [31:0] w);
    return (64'(w) * 64'd3 + 64'd3) & ~64'd3;
  endfunction

  task automatic clear_stream();
    at_pos = '0;
    stage = bmpd_pkg::PH_HEADER;
    pix_off = '0;
    info_len = '0;
    w_raw = '0;
    h_raw = '0;
    planes_val = '0;
    bpp_val = '0;
    comp_val = '0;
    row_bytes = '0;
    col_cnt = '0;
    src_rows = '0;
    chan = '0;
    keep_b = '0;
    keep_g = '0;
  endtask

  task automatic decode_byte(input bit [7:0] b, output bit got,
                             output bmpd_pkg::result_t r);
    bit [31:0] pos;
    bit [3:0] err;
    bit [31:0] h;
    bit [31:0] drow;
    longint unsigned stride;
    bit last;
    pos = at_pos;
    got = 1'b0;
    r = '0;
    err = bmpd_pkg::ST_OK;
    if (stage == bmpd_pkg::PH_HEADER) begin
      if (pos == 0) begin
        keep_b = b;
        if (file_len < HDR_LEN) err = bmpd_pkg::ST_SMALL;
      end else if (pos == 1) begin
        if (keep_b != SIG_B || b != SIG_M) err = bmpd_pkg::ST_SIGNATURE;
        keep_b = '0;
      end else begin
        // little-endian header fields
        if (pos >= 10 && pos <= 13) pix_off |= 32'(b) << (8 * (pos - 10));
        else if (pos >= 14 && pos <= 17) info_len |= 32'(b) << (8 * (pos - 14));
        else if (pos >= 18 && pos <= 21) w_raw |= 32'(b) << (8 * (pos - 18));
        else if (pos >= 22 && pos <= 25) h_raw |= 32'(b) << (8 * (pos - 22));
        else if (pos >= 26 && pos <= 27) planes_val |= 16'(b) << (8 * (pos - 26));
        else if (pos >= 28 && pos <= 29) bpp_val |= 16'(b) << (8 * (pos - 28));
        else if (pos >= 30 && pos <= 33) comp_val |= 32'(b) << (8 * (pos - 30));
        if (pos == 33) begin
          h = height_abs(h_raw);
          stride = padded_stride(w_raw);
          if (info_len < INFO_LEN || 64'd14 + 64'(info_len) > 64'(file_len)) begin
            err = bmpd_pkg::ST_INFO_SIZE;
          end else if (planes_val != 16'd1) begin
            err = bmpd_pkg::ST_PLANES;
          end else if (bpp_val != BPP_24) begin
            err = bmpd_pkg::ST_DEPTH;
          end else if (comp_val != 0) begin
            err = bmpd_pkg::ST_COMPRESSION;
          end else if (w_raw == 0 || w_raw[31] || h_raw == 0) begin
            err = bmpd_pkg::ST_DIMS;
          end else if (pix_off < HDR_LEN || pix_off >= file_len) begin
            err = bmpd_pkg::ST_OFFSET;
          end else if (64'(pix_off) + stride * 64'(h) > 64'(file_len)) begin
            err = bmpd_pkg::ST_TRUNCATED;
          end else if (w_raw > MAX_W || h > MAX_H) begin
            err = bmpd_pkg::ST_TOO_LARGE;
          end else begin
            r.kind = bmpd_pkg::KIND_HEADER;
            r.status = bmpd_pkg::ST_OK;
            r.image_width = w_raw[14:0];
            r.image_height = h[14:0];
            got = 1'b1;
            stage = bmpd_pkg::PH_PIXELS;
          end
        end
      end
      if (err != bmpd_pkg::ST_OK) begin
        r = '0;
        r.kind = bmpd_pkg::KIND_ERROR;
        r.status = err;
        got = 1'b1;
        stage = bmpd_pkg::PH_IGNORE;
      end
    end else if (stage == bmpd_pkg::PH_PIXELS && pos >= pix_off) begin
      h = height_abs(h_raw);
      stride = padded_stride(w_raw);
      if (64'(row_bytes) < 64'(w_raw) * 64'd3) begin
        if (chan == 2'd0) begin
          keep_b = b;
          chan = 2'd1;
        end else if (chan == 2'd1) begin
          keep_g = b;
          chan = 2'd2;
        end else begin
          // bottom-up files fill the picture from its last row
          drow = h_raw[31] ? src_rows : (h - 32'd1 - src_rows);
          last = (src_rows == h - 32'd1) && (col_cnt == w_raw - 32'd1);
          r.kind = bmpd_pkg::KIND_PIXEL;
          r.status = bmpd_pkg::ST_OK;
          r.red = b;
          r.green = keep_g;
          r.blue = keep_b;
          r.column = col_cnt[13:0];
          r.row = drow[13:0];
          r.last_pixel = last;
          got = 1'b1;
          chan = 2'd0;
          col_cnt++;
          if (last) stage = bmpd_pkg::PH_IGNORE;
        end
      end
      row_bytes++;
      if (64'(row_bytes) >= stride) begin
        row_bytes = '0;
        col_cnt = '0;
        chan = '0;
        src_rows++;
      end
    end
    if (64'(pos) + 64'd1 >= 64'(file_len)) clear_stream();
    else at_pos = pos + 32'd1;
  endtask

  task automatic match_field(input string what, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    bmpd_pkg::result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual kind %0d status %0d",
                 $time, res_if.kind, res_if.status);
        err_count++;
      end else begin
        want = due_results.pop_front();
        match_field("kind", want.kind, res_if.kind);
        match_field("status", want.status, res_if.status);
        match_field("red", want.red, res_if.red);
        match_field("green", want.green, res_if.green);
        match_field("blue", want.blue, res_if.blue);
        match_field("column", want.column, res_if.column);
        match_field("row", want.row, res_if.row);
        match_field("image_width", want.image_width, res_if.image_width);
        match_field("image_height", want.image_height, res_if.image_height);
        match_field("last_pixel", want.last_pixel, res_if.last_pixel);
      end
    end
  end

  // result side back-pressure in bursts
  initial begin : sink_side
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_byte(input bit [7:0] b);
    bmpd_pkg::result_t r;
    bit got;
    if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    byte_if.valid <= 1'b1;
    byte_if.data_byte <= b;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    decode_byte(b, got, r);
    if (got) due_results.push_back(r);
  endtask

  // hold the byte request low until every pending result is out
  task automatic settle();
    byte_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic lay_length(input bit [31:0] len);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.file_length <= len;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    file_len = len;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic poke_le(input int unsigned idx, input bit [31:0] val, input int unsigned n);
    for (int i = 0; i < n; i++) file_img[idx + i] = val[8*i +: 8];
  endtask

  task automatic build_header(input bit [31:0] w, input bit [31:0] h, input bit [31:0] off);
    file_img.delete();
    repeat (34) file_img.push_back('0);
    file_img[0] = SIG_B;
    file_img[1] = SIG_M;
    poke_le(10, off, 4);
    poke_le(14, INFO_LEN, 4);
    poke_le(18, w, 4);
    poke_le(22, h, 4);
    poke_le(26, 32'd1, 2);
    poke_le(28, 32'(BPP_24), 2);
    // rest of the info header and any gap before the pixels: don't care
    while (file_img.size() < off) file_img.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_pixels(input bit [31:0] w, input bit [31:0] h, input int unsigned tail);
    longint unsigned n;
    n = padded_stride(w) * 64'(height_abs(h)) + 64'(tail);
    repeat (n) file_img.push_back(8'($urandom_range(0, 255)));
  endtask

  // stream the file; a stream left mid-file is closed by shortening the length
  task automatic send_file(input bit [31:0] len);
    lay_length(len);
    foreach (file_img[i]) begin
      if (hold_odds != 0 && $urandom_range(1, hold_odds) == 1) settle();
      send_byte(file_img[i]);
    end
    if (at_pos != 0) begin
      lay_length(at_pos + 32'd1);
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic header_only(input bit [31:0] w, input bit [31:0] h, input bit [31:0] len);
    build_header(w, h, HDR_LEN);
    file_img = file_img[0:33];
    send_file(len);
  endtask

  task automatic test_short_files();
    file_img.delete();
    repeat (3) file_img.push_back(8'($urandom_range(0, 255)));
    send_file(32'd0);
    send_file(32'd1);
    build_header(1, 1, HDR_LEN);
    file_img = file_img[0:2];
    send_file(32'd53);
  endtask

  task automatic test_signature();
    for (int c = 0; c < 3; c++) begin
      build_header(1, 1, HDR_LEN);
      add_pixels(1, 1, 0);
      if (c != 1) file_img[0] = 8'h62;
      if (c != 0) file_img[1] = 8'hCD;
      send_file(file_img.size());
    end
  endtask

  task automatic test_header_checks();
    bit [31:0] len;
    // 2x2 bottom-up, 8 bytes a row: 70 bytes in all, only the header goes out
    for (int c = 0; c < 15; c++) begin
      len = 32'd70;
      build_header(2, 2, HDR_LEN);
      case (c)
        0: poke_le(14, 32'd39, 4);
        1: poke_le(14, 32'd57, 4);            // info header runs past the file
        2: poke_le(26, 32'd0, 2);
        3: poke_le(26, 32'h0101, 2);
        4: poke_le(28, 32'd32, 2);
        5: poke_le(28, 32'h1018, 2);
        6: poke_le(30, 32'd1, 4);
        7: poke_le(30, 32'h0100_0000, 4);
        8: poke_le(18, 32'd0, 4);
        9: poke_le(18, 32'h8000_0000, 4);
        10: poke_le(22, 32'd0, 4);
        11: poke_le(10, 32'd53, 4);
        12: poke_le(10, 32'd70, 4);           // offset at the very end
        13: len = 32'd69;                     // one pixel byte short
        default: poke_le(14, 32'd56, 4);      // largest info header that still fits
      endcase
      file_img = file_img[0:33];
      send_file(len);
    end
  endtask

  task automatic test_size_limits();
    header_only(32'd16385, 32'd1, 32'd54 + 32'd49156);
    header_only(32'd1, 32'd16385, 32'd54 + 32'd65540);
    header_only(32'd1, -32'sd16385, 32'd54 + 32'd65540);
    header_only(32'd16384, 32'd1, 32'd54 + 32'd49152 - 32'd1);
    // stride of a huge width must not wrap
    header_only(32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF);
    header_only(32'd1, 32'h8000_0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_small_images();
    build_header(1, 1, HDR_LEN);
    add_pixels(1, 1, 0);
    send_file(file_img.size());
    build_header(1, -32'sd1, HDR_LEN);
    add_pixels(1, -32'sd1, 0);
    send_file(file_img.size());
    build_header(3, 2, HDR_LEN);
    add_pixels(3, 2, 0);
    send_file(file_img.size());
    build_header(4, -32'sd3, HDR_LEN);
    add_pixels(4, -32'sd3, 0);
    send_file(file_img.size());
    // gap before the pixels and trailing bytes after them
    build_header(5, 2, 32'd61);
    add_pixels(5, 2, 5);
    send_file(file_img.size());
  endtask

  task automatic test_length_register();
    build_header(2, 1, HDR_LEN);
    add_pixels(2, 1, 0);
    send_file(32'hFFFF_FFFF);
    repeat (4) begin
      build_header(1, 1, HDR_LEN);
      add_pixels(1, 1, 0);
      send_file($urandom());
    end
  endtask

  // largest sizes that are still accepted, header only
  task automatic test_largest_images();
    header_only(32'd16384, -32'sd1, 32'd54 + 32'd49152);
    header_only(32'd1, 32'd16384, 32'd54 + 32'd65536);
  endtask

  task automatic test_random_files(input int unsigned byte_goal, input bit calm);
    int unsigned sent;
    int unsigned pick;
    bit [31:0] w;
    bit [31:0] h;
    sent = 0;
    while (sent < byte_goal) begin
      if (calm) begin
        src_odds = 0;
        sink_odds = 0;
      end else begin
        src_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 16);
        sink_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 16);
      end
      pick = $urandom_range(0, 99);
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      if ($urandom_range(0, 1) == 1) h = -h;
      if (pick < 10) begin
        // noise of random length
        file_img.delete();
        repeat ($urandom_range(0, 72)) file_img.push_back(8'($urandom_range(0, 255)));
        send_file($urandom_range(0, 70));
      end else begin
        build_header(w, h, $urandom_range(54, 58));
        add_pixels(w, h, $urandom_range(0, 3));
        if (pick < 25) file_img[$urandom_range(0, 33)] = 8'($urandom_range(0, 255));
        else if (pick < 30) repeat ($urandom_range(1, 4)) void'(file_img.pop_back());
        send_file(file_img.size());
      end
      sent += file_img.size();
    end
  endtask

  initial begin
    byte_if.valid <= 1'b0;
    byte_if.data_byte <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.file_length <= '0;
    err_count = 0;
    src_odds = 6;
    sink_odds = 6;
    hold_odds = 0;
    file_len = HDR_LEN;
    clear_stream();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_files();
    test_signature();
    test_header_checks();
    test_size_limits();
    test_small_images();
    test_length_register();
    src_odds = 32;
    sink_odds = 32;
    test_largest_images();
    hold_odds = 200;
    test_random_files(200, 1'b0);
    hold_odds = 0;
    test_random_files(60, 1'b1);

    settle();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
